@@ src/lu2x_pkg.sv @@
// ----------------------------------------------------------------------------
// lu2x_pkg
// Shared types, constants and the six-tap half-pel filter for the 2x luma
// upscaler.
// ----------------------------------------------------------------------------
package lu2x_pkg;

   localparam int BORDER     = 3;
   localparam int TAPS       = 2 * BORDER;
   localparam int LINE_ROWS  = TAPS - 1;
   localparam int PIX_W      = 8;
   localparam int ROW_W      = 13;
   localparam int SRC_X_W    = 10;
   localparam int SRC_Y_W    = 12;
   localparam int CFG_WIDTH_W  = 11;
   localparam int CFG_HEIGHT_W = 12;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 12;
   localparam int COL_WORD_W = LINE_ROWS * PIX_W;

   localparam logic [CFG_WIDTH_W-1:0]  WIDTH_RESET  = 11'd400;
   localparam logic [CFG_HEIGHT_W-1:0] HEIGHT_RESET = 12'd226;

   localparam logic [CSR_IDX_W-1:0] CSR_SOURCE_WIDTH  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_SOURCE_HEIGHT = 1'b1;

   typedef logic [PIX_W-1:0] pixel_type;
   typedef logic [COL_WORD_W-1:0] col_word_type;

   typedef struct packed {
      logic                 emit;
      logic                 last;
      logic [SRC_X_W-1:0]   src_x;
      logic [SRC_Y_W-1:0]   src_y;
   } pos_type;

   // (p0 - 5p1 + 20p2 + 20p3 - 5p4 + p5 + 16) >>> 5, clipped to 0..255
   function automatic pixel_type six_tap(input pixel_type p0, input pixel_type p1,
                                         input pixel_type p2, input pixel_type p3,
                                         input pixel_type p4, input pixel_type p5);
      logic signed [15:0] a0, a1, a2, a3, a4, a5;
      logic signed [15:0] outer, mid;
      logic signed [15:0] f;
      logic signed [15:0] r;
      pixel_type          res;
      a0    = $signed({8'h00, p0});
      a1    = $signed({8'h00, p1});
      a2    = $signed({8'h00, p2});
      a3    = $signed({8'h00, p3});
      a4    = $signed({8'h00, p4});
      a5    = $signed({8'h00, p5});
      outer = a1 + a4;
      mid   = a2 + a3;
      f     = a0 + a5 - (outer <<< 2) - outer + (mid <<< 4) + (mid <<< 2) + 16'sd16;
      r     = f >>> 5;
      if (r < 16'sd0) begin
         res = 8'd0;
      end else if (r > 16'sd255) begin
         res = 8'd255;
      end else begin
         res = r[7:0];
      end
      return res;
   endfunction

endpackage

@@ src/lu2x_req_if.sv @@
// ----------------------------------------------------------------------------
// lu2x_req_if
// Input pixel channel: one padded-frame luma sample per beat.
// ----------------------------------------------------------------------------
interface lu2x_req_if;
   import lu2x_pkg::*;

   logic      valid;
   logic      ready;
   pixel_type luma;
   logic      frame_start;

   modport source (output valid, luma, frame_start, input ready);
   modport sink   (input valid, luma, frame_start, output ready);

endinterface

@@ src/lu2x_rsp_if.sv @@
// ----------------------------------------------------------------------------
// lu2x_rsp_if
// Result channel: one 2x2 output quad per beat.
// ----------------------------------------------------------------------------
interface lu2x_rsp_if;
   import lu2x_pkg::*;

   logic               valid;
   logic               ready;
   logic [SRC_X_W-1:0] src_x;
   logic [SRC_Y_W-1:0] src_y;
   pixel_type          out_top_left;
   pixel_type          out_top_right;
   pixel_type          out_bottom_left;
   pixel_type          out_bottom_right;
   logic               frame_done;

   modport source (output valid, src_x, src_y, out_top_left, out_top_right,
                   out_bottom_left, out_bottom_right, frame_done, input ready);
   modport sink   (input valid, src_x, src_y, out_top_left, out_top_right,
                   out_bottom_left, out_bottom_right, frame_done, output ready);

endinterface

@@ src/lu2x_csr_if.sv @@
// ----------------------------------------------------------------------------
// lu2x_csr_if
// Register write channel: register index and write data per beat.
// ----------------------------------------------------------------------------
interface lu2x_csr_if;
   import lu2x_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);

endinterface

@@ src/lu2x_line_store.sv @@
// ----------------------------------------------------------------------------
// lu2x_line_store
// Five padded rows held column-wise: one word per column, one read and one
// write port, registered read with forwarding of a same-cycle write.
// ----------------------------------------------------------------------------
module lu2x_line_store #(
   parameter int DEPTH = 1030,
   parameter int AW    = 11
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  rd_en,
   input  logic [AW-1:0]         rd_addr,
   input  logic                  wr_en,
   input  logic [AW-1:0]         wr_addr,
   input  lu2x_pkg::col_word_type wr_data,
   output lu2x_pkg::col_word_type rd_data
);
   import lu2x_pkg::*;

   col_word_type store_mem [DEPTH];
   col_word_type rd_q_ff;
   col_word_type byp_data_ff;
   logic         byp_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_q_ff     <= store_mem[rd_addr];
         byp_data_ff <= wr_data;
      end
   end

   // a column rewritten in the same cycle it is read (frame restart)
   always_ff @(posedge clock) begin
      if (reset) begin
         byp_ff <= 1'b0;
      end else if (rd_en) begin
         byp_ff <= wr_en && (wr_addr == rd_addr);
      end
   end

   assign rd_data = byp_ff ? byp_data_ff : rd_q_ff;

endmodule

@@ src/lu2x_window.sv @@
// ----------------------------------------------------------------------------
// lu2x_window
// Forms the six-sample column, runs the vertical filter and keeps the
// horizontal history of the centre row and of the vertical results.
// ----------------------------------------------------------------------------
module lu2x_window (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               shift,
   input  lu2x_pkg::col_word_type             col_word,
   input  lu2x_pkg::pixel_type                pix,
   output lu2x_pkg::col_word_type             wb_word,
   output lu2x_pkg::pixel_type [lu2x_pkg::TAPS-1:0] h_snap,
   output lu2x_pkg::pixel_type [lu2x_pkg::TAPS-1:0] v_snap
);
   import lu2x_pkg::*;

   pixel_type [TAPS-1:0]  col;
   pixel_type             vert;
   pixel_type [TAPS-2:0]  h_ff;
   pixel_type [TAPS-2:0]  v_ff;

   always_comb begin
      for (int k = 0; k < LINE_ROWS; k++) begin
         col[k] = col_word[k*PIX_W +: PIX_W];
      end
      col[TAPS-1] = pix;
   end

   // column shifts up by one row on write-back
   always_comb begin
      for (int k = 0; k < LINE_ROWS; k++) begin
         wb_word[k*PIX_W +: PIX_W] = col[k+1];
      end
   end

   assign vert = six_tap(col[0], col[1], col[2], col[3], col[4], col[5]);

   always_comb begin
      for (int j = 0; j < TAPS-1; j++) begin
         h_snap[j] = h_ff[j];
         v_snap[j] = v_ff[j];
      end
      h_snap[TAPS-1] = col[BORDER-1];
      v_snap[TAPS-1] = vert;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         h_ff <= '0;
         v_ff <= '0;
      end else if (shift) begin
         for (int j = 0; j < TAPS-1; j++) begin
            h_ff[j] <= h_snap[j+1];
            v_ff[j] <= v_snap[j+1];
         end
      end
   end

endmodule

@@ src/lu2x_scan.sv @@
// ----------------------------------------------------------------------------
// lu2x_scan
// Size registers and the raster position counters of the padded frame.
// ----------------------------------------------------------------------------
module lu2x_scan #(
   parameter int MAX_WIDTH = 1024,
   parameter int AW        = 11,
   parameter int PW_W      = 11
) (
   input  logic               clock,
   input  logic               reset,
   lu2x_csr_if.sink           csr_chan,
   input  logic               accept,
   input  logic               frame_start,
   output logic [AW-1:0]      addr,
   output lu2x_pkg::pos_type  pos
);
   import lu2x_pkg::*;

   logic [CFG_WIDTH_W-1:0]  width_ff;
   logic [CFG_HEIGHT_W-1:0] height_ff;
   logic [AW-1:0]           col_ff, col_in;
   logic [ROW_W-1:0]        row_ff, row_in;

   logic [PW_W-1:0]         sw, pw, nc;
   logic [CFG_HEIGHT_W-1:0] sh;
   logic [ROW_W-1:0]        ph, r0, r1, cy, ny;
   logic [AW-1:0]           c0, cx;

   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
      end else if (csr_chan.valid) begin
         unique case (csr_chan.index)
            CSR_SOURCE_WIDTH:  width_ff  <= csr_chan.data[CFG_WIDTH_W-1:0];
            CSR_SOURCE_HEIGHT: height_ff <= csr_chan.data[CFG_HEIGHT_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      if (width_ff == '0) begin
         sw = PW_W'(1);
      end else if (width_ff > MAX_WIDTH) begin
         sw = PW_W'(MAX_WIDTH);
      end else begin
         sw = PW_W'(width_ff);
      end
      pw = sw + PW_W'(TAPS);
      sh = (height_ff == '0) ? CFG_HEIGHT_W'(1) : height_ff;
      ph = {1'b0, sh} + ROW_W'(TAPS);

      c0 = frame_start ? '0 : col_ff;
      r0 = frame_start ? '0 : row_ff;

      // stale position after a size change wraps first
      if (PW_W'(c0) >= pw) begin
         cx = '0;
         r1 = r0 + ROW_W'(1);
      end else begin
         cx = c0;
         r1 = r0;
      end
      cy = (r1 >= ph) ? '0 : r1;

      nc = PW_W'(cx) + PW_W'(1);
      ny = cy + ROW_W'(1);
      if (nc >= pw) begin
         col_in = '0;
         row_in = (ny >= ph) ? '0 : ny;
      end else begin
         col_in = AW'(nc);
         row_in = cy;
      end

      pos.emit  = (cx >= AW'(TAPS)) && (cy >= ROW_W'(TAPS));
      pos.last  = (PW_W'(cx) == pw - PW_W'(1)) && (cy == ph - ROW_W'(1));
      pos.src_x = SRC_X_W'(cx - AW'(TAPS));
      pos.src_y = SRC_Y_W'(cy - ROW_W'(TAPS));
   end

   assign addr = cx;

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (accept) begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

endmodule

@@ src/luma_upscale_2x_six_tap_unit.sv @@
// ----------------------------------------------------------------------------
// luma_upscale_2x_six_tap_unit
// Streaming 2x luma upscaler with six-tap half-pel interpolation.
// ----------------------------------------------------------------------------
// Takes one padded-frame luma sample per clock when not stalled and returns
// one 2x2 quad per source pixel through stage 1 (line store read), stage 2
// (column/vertical filter) and the result register (horizontal filters). The
// line store is one word of five pixels per padded column with a single read
// and write port, touched once per sample; that port and the six-tap filters
// set the rate of one sample per cycle when not stalled. The line store needs
// no clearing after reset: every column is written on the first padded row
// before use. Size registers may be written only while the unit is idle.
module luma_upscale_2x_six_tap_unit #(
   parameter int MAX_WIDTH = 1024
) (
   input  logic       clock,
   input  logic       reset,
   lu2x_req_if.sink   req_chan,
   lu2x_rsp_if.source rsp_chan,
   lu2x_csr_if.sink   csr_chan
);
   import lu2x_pkg::*;

   localparam int DEPTH = MAX_WIDTH + TAPS;
   localparam int AW    = $clog2(DEPTH);
   localparam int PW_W  = $clog2(DEPTH + 1);

   logic                  accept;
   logic                  req_ready;
   logic [AW-1:0]         scan_addr;
   pos_type               scan_pos;

   logic                  s1_valid_ff;
   pixel_type             s1_pix_ff;
   pos_type               s1_pos_ff;
   logic [AW-1:0]         s1_addr_ff;

   logic                  s2_valid_ff;
   pos_type               s2_pos_ff;
   pixel_type [TAPS-1:0]  s2_h_ff;
   pixel_type [TAPS-1:0]  s2_v_ff;

   logic                  rsp_valid_ff;
   logic [SRC_X_W-1:0]    src_x_ff;
   logic [SRC_Y_W-1:0]    src_y_ff;
   pixel_type             top_left_ff, top_right_ff, bottom_left_ff, bottom_right_ff;
   logic                  frame_done_ff;

   logic                  out_ok, s2_free, s2_adv, s1_adv, s2_load;
   col_word_type          rd_word, wb_word;
   pixel_type [TAPS-1:0]  h_snap, v_snap;

   // pipeline flow: each stage moves when the next one is empty or moving
   assign out_ok    = !rsp_valid_ff || rsp_chan.ready;
   assign s2_adv    = s2_valid_ff && out_ok;
   assign s2_free   = !s2_valid_ff || out_ok;
   assign s1_adv    = s1_valid_ff && (!s1_pos_ff.emit || s2_free);
   assign s2_load   = s1_adv && s1_pos_ff.emit;
   assign req_ready = !s1_valid_ff || s1_adv;
   assign accept    = req_chan.valid && req_ready;

   assign req_chan.ready = req_ready;

   lu2x_scan #(
      .MAX_WIDTH (MAX_WIDTH),
      .AW        (AW),
      .PW_W      (PW_W)
   ) u_scan (
      .clock       (clock),
      .reset       (reset),
      .csr_chan    (csr_chan),
      .accept      (accept),
      .frame_start (req_chan.frame_start),
      .addr        (scan_addr),
      .pos         (scan_pos)
   );

   lu2x_line_store #(
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_line_store (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (accept),
      .rd_addr (scan_addr),
      .wr_en   (s1_adv),
      .wr_addr (s1_addr_ff),
      .wr_data (wb_word),
      .rd_data (rd_word)
   );

   lu2x_window u_window (
      .clock    (clock),
      .reset    (reset),
      .shift    (s1_adv),
      .col_word (rd_word),
      .pix      (s1_pix_ff),
      .wb_word  (wb_word),
      .h_snap   (h_snap),
      .v_snap   (v_snap)
   );

   // stage 1: sample and position, line store read in flight
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_ready) begin
         s1_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_pix_ff  <= req_chan.luma;
         s1_pos_ff  <= scan_pos;
         s1_addr_ff <= scan_addr;
      end
   end

   // stage 2: window snapshot for quads inside the source area
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (s2_load) begin
         s2_valid_ff <= 1'b1;
      end else if (s2_adv) begin
         s2_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_load) begin
         s2_pos_ff <= s1_pos_ff;
         s2_h_ff   <= h_snap;
         s2_v_ff   <= v_snap;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s2_adv) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_adv) begin
         src_x_ff        <= s2_pos_ff.src_x;
         src_y_ff        <= s2_pos_ff.src_y;
         top_left_ff     <= s2_h_ff[BORDER-1];
         top_right_ff    <= six_tap(s2_h_ff[0], s2_h_ff[1], s2_h_ff[2],
                                    s2_h_ff[3], s2_h_ff[4], s2_h_ff[5]);
         bottom_left_ff  <= s2_v_ff[BORDER-1];
         bottom_right_ff <= six_tap(s2_v_ff[0], s2_v_ff[1], s2_v_ff[2],
                                    s2_v_ff[3], s2_v_ff[4], s2_v_ff[5]);
         frame_done_ff   <= s2_pos_ff.last;
      end
   end

   assign rsp_chan.valid            = rsp_valid_ff;
   assign rsp_chan.src_x            = src_x_ff;
   assign rsp_chan.src_y            = src_y_ff;
   assign rsp_chan.out_top_left     = top_left_ff;
   assign rsp_chan.out_top_right    = top_right_ff;
   assign rsp_chan.out_bottom_left  = bottom_left_ff;
   assign rsp_chan.out_bottom_right = bottom_right_ff;
   assign rsp_chan.frame_done       = frame_done_ff;

`ifndef NO_ASSERTIONS
   a_accept_fills_s1: assert property (@(posedge clock) disable iff (reset)
      accept |=> s1_valid_ff)
      else $error("accepted beat did not reach stage 1");

   a_s2_holds_on_stall: assert property (@(posedge clock) disable iff (reset)
      (s2_valid_ff && !out_ok) |=> (s2_valid_ff && $stable(s2_pos_ff)))
      else $error("stage 2 lost a quad while the result register was stalled");

   a_no_s2_overwrite: assert property (@(posedge clock) disable iff (reset)
      s2_load |-> (!s2_valid_ff || s2_adv))
      else $error("stage 2 overwritten before its quad moved on");

   a_result_from_s2: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(s2_valid_ff))
      else $error("result raised without a quad in stage 2");
`endif

endmodule
